FILE: sv/bbp_pkg.sv
package bbp_pkg;

  // Default table geometry, handed to the top level as parameter defaults.
  localparam int unsigned TableEntriesDef = 1024;
  localparam int unsigned IndexShiftDef   = 2;

  // Fixed payload widths.
  localparam int unsigned AddrWidth = 64;
  localparam int unsigned CtrWidth  = 2;

  // Two-bit saturating counter codes.
  localparam logic [CtrWidth-1:0] CtrStrongNotTaken = 2'd0;
  localparam logic [CtrWidth-1:0] CtrWeakNotTaken   = 2'd1;
  localparam logic [CtrWidth-1:0] CtrWeakTaken      = 2'd2;
  localparam logic [CtrWidth-1:0] CtrStrongTaken    = 2'd3;

  // Function codes of an input item.
  localparam logic FuncRegister = 1'b0;
  localparam logic FuncResolve  = 1'b1;

  // One table entry as held in the memory.
  typedef struct packed {
    logic                valid;
    logic [CtrWidth-1:0] ctr;
  } bbp_entry_t;

  localparam int unsigned EntryWidth = $bits(bbp_entry_t);

  // Control sequencer states.
  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StIndex,
    StUpdate
  } bbp_state_e;

endpackage

FILE: sv/bbp_in_if.sv
interface bbp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [bbp_pkg::AddrWidth-1:0]  address;
  logic [bbp_pkg::AddrWidth-1:0]  target_address;

  modport source (output valid, output func, output address, output target_address,
                  input ready);
  modport sink   (input valid, input func, input address, input target_address,
                  output ready);
endinterface

FILE: sv/bbp_out_if.sv
interface bbp_out_if;
  logic valid;
  logic ready;
  logic predicted_taken;
  logic actual_taken;
  logic mispredicted;

  modport source (output valid, output predicted_taken, output actual_taken,
                  output mispredicted, input ready);
  modport sink   (input valid, input predicted_taken, input actual_taken,
                  input mispredicted, output ready);
endinterface

FILE: sv/bbp_ram.sv
module bbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth)-1:0]         waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth)-1:0]         raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bimodal_branch_predictor.sv
// Two-bit bimodal branch predictor. The table of valid bits and saturating
// counters lives in one synchronous memory with a registered read. After reset
// a clearing pass writes every entry to invalid / strong not taken, one entry
// per cycle, so no item is accepted until the pass is done. When TableEntries
// is a power of two, an item is accepted with its table read issued and then
// updated; otherwise the table index (address >> IndexShift) mod TableEntries
// is first reduced by a remainder unit, eight address bits per cycle over
// eight steps. Items are handled one at a time, each with one table read and,
// for a resolve, one write-back. Each result sits in an output register; a new
// item is taken while it waits, and only the table update stalls until the
// result slot is free.
module bimodal_branch_predictor #(
  parameter int unsigned TableEntries = bbp_pkg::TableEntriesDef,
  parameter int unsigned IndexShift   = bbp_pkg::IndexShiftDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbp_in_if.sink    in_i,
  bbp_out_if.source out_o
);

  localparam int unsigned IdxW        = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam bit          IsPow2      = (TableEntries & (TableEntries - 1)) == 0;
  localparam int unsigned BitsPerStep = 8;
  localparam int unsigned ModSteps    = bbp_pkg::AddrWidth / BitsPerStep;
  localparam int unsigned StepW       = $clog2(ModSteps);
  localparam logic [IdxW:0]   Modulus   = TableEntries[IdxW:0];
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(TableEntries - 1);
  localparam logic [StepW-1:0] LastStep = StepW'(ModSteps - 1);

  bbp_pkg::bbp_state_e state_q, state_d;

  logic [IdxW-1:0]               clr_q, clr_d;
  logic                          func_q, func_d;
  logic [bbp_pkg::AddrWidth-1:0] addr_q, addr_d;
  logic [bbp_pkg::AddrWidth-1:0] saved_addr_q, saved_addr_d;
  logic [bbp_pkg::AddrWidth-1:0] saved_tgt_q, saved_tgt_d;
  logic                          saved_pred_q, saved_pred_d;
  logic [bbp_pkg::AddrWidth-1:0] key_q, key_d;
  logic [IdxW-1:0]               rem_q, rem_d;
  logic [StepW-1:0]              step_q, step_d;
  logic [IdxW-1:0]               idx_q, idx_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_pred_q, out_pred_d;
  logic                          out_act_q, out_act_d;
  logic                          out_mis_q, out_mis_d;

  logic [bbp_pkg::AddrWidth-1:0] key_shift;
  logic [IdxW-1:0]               rem_next;
  logic                          slot_free;
  logic                          taken;
  logic                          pred;

  logic                          ram_we;
  logic [IdxW-1:0]               ram_waddr;
  bbp_pkg::bbp_entry_t           ram_wdata;
  logic                          ram_re;
  logic [IdxW-1:0]               ram_raddr;
  bbp_pkg::bbp_entry_t           ram_rdata;

  // Saturating counter step towards the outcome.
  function automatic logic [bbp_pkg::CtrWidth-1:0] step_ctr(
    input logic [bbp_pkg::CtrWidth-1:0] ctr,
    input logic                         tk
  );
    logic [bbp_pkg::CtrWidth-1:0] res;
    res = ctr;
    if (tk) begin
      if (ctr != bbp_pkg::CtrStrongTaken) res = ctr + 1'b1;
    end else begin
      if (ctr != bbp_pkg::CtrStrongNotTaken) res = ctr - 1'b1;
    end
    return res;
  endfunction

  bbp_ram #(
    .Width (bbp_pkg::EntryWidth),
    .Depth (TableEntries)
  ) u_bbp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A register item indexes by its own address, a resolve item by the saved branch.
  assign key_shift = ((in_i.func == bbp_pkg::FuncResolve) ? saved_addr_q : in_i.address)
                     >> IndexShift;
  assign slot_free = !out_valid_q || out_o.ready;
  assign taken     = (addr_q == saved_tgt_q);
  assign pred      = ram_rdata.valid & ram_rdata.ctr[1];

  // Remainder unit: eight restoring steps of the modulo, most significant bit first.
  always_comb begin
    logic [IdxW:0]   t;
    logic [IdxW-1:0] r;
    r = rem_q;
    for (int i = 0; i < BitsPerStep; i++) begin
      t = {r, key_q[bbp_pkg::AddrWidth-1-i]};
      if (t >= Modulus) t = t - Modulus;
      r = t[IdxW-1:0];
    end
    rem_next = r;
  end

  // Sequencer: clearing pass, index reduction, table read and write-back.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    func_d       = func_q;
    addr_d       = addr_q;
    saved_addr_d = saved_addr_q;
    saved_tgt_d  = saved_tgt_q;
    saved_pred_d = saved_pred_q;
    key_d        = key_q;
    rem_d        = rem_q;
    step_d       = step_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_pred_d   = out_pred_q;
    out_act_d    = out_act_q;
    out_mis_d    = out_mis_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = idx_q;
    in_i.ready   = 1'b0;

    unique case (state_q)
      bbp_pkg::StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastIdx) begin
          state_d = bbp_pkg::StIdle;
        end
      end

      bbp_pkg::StIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          func_d = in_i.func;
          addr_d = in_i.address;
          if (in_i.func == bbp_pkg::FuncRegister) begin
            saved_addr_d = in_i.address;
            saved_tgt_d  = in_i.target_address;
          end
          if (IsPow2) begin
            ram_re    = 1'b1;
            ram_raddr = key_shift[IdxW-1:0];
            idx_d     = key_shift[IdxW-1:0];
            state_d   = bbp_pkg::StUpdate;
          end else begin
            key_d   = key_shift;
            rem_d   = '0;
            step_d  = '0;
            state_d = bbp_pkg::StIndex;
          end
        end
      end

      bbp_pkg::StIndex: begin
        key_d  = key_q << BitsPerStep;
        rem_d  = rem_next;
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          ram_re    = 1'b1;
          ram_raddr = rem_next;
          idx_d     = rem_next;
          state_d   = bbp_pkg::StUpdate;
        end
      end

      bbp_pkg::StUpdate: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (func_q == bbp_pkg::FuncResolve) begin
            ram_we          = 1'b1;
            ram_waddr       = idx_q;
            ram_wdata.valid = 1'b1;
            ram_wdata.ctr   = step_ctr(ram_rdata.ctr, taken);
            out_pred_d      = saved_pred_q;
            out_act_d       = taken;
            out_mis_d       = taken ^ saved_pred_q;
          end else begin
            saved_pred_d = pred;
            out_pred_d   = pred;
            out_act_d    = 1'b0;
            out_mis_d    = 1'b0;
          end
          state_d = bbp_pkg::StIdle;
        end
      end

      default: begin
        state_d = bbp_pkg::StIdle;
      end
    endcase
  end

  // Control and saved branch state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bbp_pkg::StClear;
      clr_q        <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      saved_addr_q <= '0;
      saved_tgt_q  <= '0;
      saved_pred_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      step_q       <= step_d;
      out_valid_q  <= out_valid_d;
      saved_addr_q <= saved_addr_d;
      saved_tgt_q  <= saved_tgt_d;
      saved_pred_q <= saved_pred_d;
    end
  end

  // Payload of the item in flight and of the waiting result.
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    addr_q     <= addr_d;
    key_q      <= key_d;
    rem_q      <= rem_d;
    idx_q      <= idx_d;
    out_pred_q <= out_pred_d;
    out_act_q  <= out_act_d;
    out_mis_q  <= out_mis_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.predicted_taken = out_pred_q;
  assign out_o.actual_taken    = out_act_q;
  assign out_o.mispredicted    = out_mis_q;

endmodule

FILE: sv/bbp_checker.sv
module bbp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_pred_i,
  input logic out_act_i,
  input logic out_mis_i
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pred_i)
      && $stable(out_act_i) && $stable(out_mis_i))
    else $error("stalled result changed");

  // A mispredict is only flagged where prediction and outcome disagree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_mis_i |-> out_pred_i != out_act_i)
    else $error("mispredict flag inconsistent");

  // One item at a time: no item is taken in the cycle after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted back to back");

  // The table clearing pass holds off input items right after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i && !out_valid_i)
    else $error("ready during clearing pass");

endmodule

bind bimodal_branch_predictor bbp_checker u_bbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pred_i  (out_o.predicted_taken),
  .out_act_i   (out_o.actual_taken),
  .out_mis_i   (out_o.mispredicted)
);

FILE: sim/bimodal_branch_predictor_tb.sv
`timescale 1ns / 100ps

module bimodal_branch_predictor_tb;

  localparam int unsigned DirectedRows = 21;
  localparam int unsigned RandomItems  = 1000;
  localparam int unsigned DrainCycles  = 32;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PoolSize     = 16;
  localparam logic [bbp_pkg::AddrWidth-1:0] AllOnes = {bbp_pkg::AddrWidth{1'b1}};

  // One result item as the block reports it.
  typedef struct packed {
    logic predicted_taken;
    logic actual_taken;
    logic mispredicted;
  } outcome_t;

  // One row of the directed table; typed rows carry their own expectation.
  typedef struct packed {
    logic                          func;
    logic [bbp_pkg::AddrWidth-1:0] addr;
    logic [bbp_pkg::AddrWidth-1:0] target;
    bit                            typed;
    outcome_t                      outcome;
  } stim_row_t;

  localparam outcome_t OutQuiet      = '{1'b0, 1'b0, 1'b0};
  localparam outcome_t OutMissTaken  = '{1'b0, 1'b1, 1'b1};
  localparam outcome_t OutFromTable  = '{1'b0, 1'b0, 1'b0};

  logic clk_i;
  logic rst_ni;

  bbp_in_if  branch_in ();
  bbp_out_if result_out ();

  bimodal_branch_predictor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (branch_in),
    .out_o  (result_out)
  );

  // Shadow copy of the branch history table and the saved branch.
  logic                          bht_valid [bbp_pkg::TableEntriesDef];
  logic [bbp_pkg::CtrWidth-1:0]  bht_ctr   [bbp_pkg::TableEntriesDef];
  logic [bbp_pkg::AddrWidth-1:0] last_branch_addr;
  logic [bbp_pkg::AddrWidth-1:0] last_target_addr;
  logic                          last_prediction;

  outcome_t pending_outcomes [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned event_count;
  int unsigned register_count;
  int unsigned resolve_count;
  int unsigned result_count;
  int unsigned mispredict_count;
  int unsigned taken_pred_count;
  int unsigned error_count;
  int unsigned cycle_count;

  // The directed table: reset behaviour, saturation at both ends, aliasing
  // and the extremes of the address fields.
  stim_row_t directed_rows [DirectedRows] = '{
    // Resolve before any branch: the saved target is zero, so this is taken.
    '{bbp_pkg::FuncResolve,  64'h0,    64'h0,    1'b1, OutMissTaken},
    '{bbp_pkg::FuncResolve,  AllOnes,  64'h0,    1'b1, OutQuiet},
    // Counter already at strong not taken stays there.
    '{bbp_pkg::FuncResolve,  AllOnes,  64'h0,    1'b1, OutQuiet},
    '{bbp_pkg::FuncRegister, 64'h0,    AllOnes,  1'b1, OutQuiet},
    // Repeated resolves walk the counter up to strong taken and hold it.
    '{bbp_pkg::FuncResolve,  AllOnes,  AllOnes,  1'b1, OutMissTaken},
    '{bbp_pkg::FuncResolve,  AllOnes,  AllOnes,  1'b1, OutMissTaken},
    '{bbp_pkg::FuncResolve,  AllOnes,  AllOnes,  1'b1, OutMissTaken},
    '{bbp_pkg::FuncResolve,  AllOnes,  AllOnes,  1'b1, OutMissTaken},
    '{bbp_pkg::FuncRegister, 64'h3,    64'h1000, 1'b0, OutFromTable},
    '{bbp_pkg::FuncResolve,  64'h1000, 64'h0,    1'b0, OutFromTable},
    '{bbp_pkg::FuncResolve,  64'h1004, 64'h0,    1'b0, OutFromTable},
    '{bbp_pkg::FuncRegister, 64'h0,    64'h0,    1'b0, OutFromTable},
    '{bbp_pkg::FuncResolve,  64'h5,    64'h0,    1'b0, OutFromTable},
    '{bbp_pkg::FuncRegister, 64'h0,    64'h0,    1'b0, OutFromTable},
    // Top entry of the table is still invalid, so it predicts not taken.
    '{bbp_pkg::FuncRegister, AllOnes,  64'h0,    1'b1, OutQuiet},
    '{bbp_pkg::FuncResolve,  64'h0,    AllOnes,  1'b1, OutMissTaken},
    '{bbp_pkg::FuncResolve,  64'h0,    AllOnes,  1'b1, OutMissTaken},
    '{bbp_pkg::FuncRegister, 64'hFFFF_FFFF_FFFF_FFFC, 64'hAAAA_AAAA_AAAA_AAAA,
      1'b0, OutFromTable},
    '{bbp_pkg::FuncResolve,  64'hAAAA_AAAA_AAAA_AAAA, 64'h0, 1'b0, OutFromTable},
    // This address folds onto entry zero.
    '{bbp_pkg::FuncRegister, 64'h1000, 64'h5555_5555_5555_5555, 1'b0, OutFromTable},
    '{bbp_pkg::FuncResolve,  64'h5555_5555_5555_5555, 64'h0, 1'b0, OutFromTable}
  };

  // Works out the result of one item and advances the shadow state.
  function automatic outcome_t predict_branch_outcome(
    input logic                          func,
    input logic [bbp_pkg::AddrWidth-1:0] addr,
    input logic [bbp_pkg::AddrWidth-1:0] target
  );
    outcome_t                      res;
    logic [bbp_pkg::AddrWidth-1:0] shifted;
    int unsigned                   idx;
    logic                          taken;
    res = OutQuiet;
    if (func == bbp_pkg::FuncRegister) begin
      shifted = addr >> bbp_pkg::IndexShiftDef;
      idx = 32'(shifted % bbp_pkg::TableEntriesDef);
      res.predicted_taken = bht_valid[idx] &&
                            (bht_ctr[idx] == bbp_pkg::CtrWeakTaken ||
                             bht_ctr[idx] == bbp_pkg::CtrStrongTaken);
      last_branch_addr = addr;
      last_target_addr = target;
      last_prediction  = res.predicted_taken;
    end else begin
      shifted = last_branch_addr >> bbp_pkg::IndexShiftDef;
      idx = 32'(shifted % bbp_pkg::TableEntriesDef);
      taken = (addr == last_target_addr);
      bht_valid[idx] = 1'b1;
      if (taken && bht_ctr[idx] != bbp_pkg::CtrStrongTaken) begin
        bht_ctr[idx] = bht_ctr[idx] + 1'b1;
      end else if (!taken && bht_ctr[idx] != bbp_pkg::CtrStrongNotTaken) begin
        bht_ctr[idx] = bht_ctr[idx] - 1'b1;
      end
      res.predicted_taken = last_prediction;
      res.actual_taken    = taken;
      res.mispredicted    = taken != last_prediction;
    end
    return res;
  endfunction

  // Offers one item after a random gap and books its expected result once
  // it has been taken.
  task automatic send_branch_event(input logic func,
                                   input logic [bbp_pkg::AddrWidth-1:0] addr,
                                   input logic [bbp_pkg::AddrWidth-1:0] target,
                                   input bit typed,
                                   input outcome_t typed_outcome);
    outcome_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      branch_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    branch_in.valid          <= 1'b1;
    branch_in.func           <= func;
    branch_in.address        <= addr;
    branch_in.target_address <= target;
    do @(posedge clk_i); while (branch_in.ready !== 1'b1);
    predicted = predict_branch_outcome(func, addr, target);
    pending_outcomes.push_back(typed ? typed_outcome : predicted);
    event_count++;
    if (func == bbp_pkg::FuncRegister) register_count++;
    else resolve_count++;
  endtask

  // Clock and free-running cycle limit.
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    result_out.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && result_out.valid === 1'b1 && result_out.ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $error("result item with no expectation waiting");
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        result_count++;
        if (result_out.mispredicted === 1'b1) mispredict_count++;
        if (result_out.predicted_taken === 1'b1) taken_pred_count++;
        if (result_out.predicted_taken !== want.predicted_taken) begin
          $error("predicted_taken: expected %0b, got %0b",
                 want.predicted_taken, result_out.predicted_taken);
          error_count++;
        end
        if (result_out.actual_taken !== want.actual_taken) begin
          $error("actual_taken: expected %0b, got %0b",
                 want.actual_taken, result_out.actual_taken);
          error_count++;
        end
        if (result_out.mispredicted !== want.mispredicted) begin
          $error("mispredicted: expected %0b, got %0b",
                 want.mispredicted, result_out.mispredicted);
          error_count++;
        end
      end
    end
  end

  initial begin : run_stimulus
    logic [bbp_pkg::AddrWidth-1:0] branch_pool [PoolSize];
    int unsigned                   pool_bias   [PoolSize];
    logic [bbp_pkg::AddrWidth-1:0] branch_addr;
    logic [bbp_pkg::AddrWidth-1:0] target;
    logic [bbp_pkg::AddrWidth-1:0] next_addr;
    int unsigned                   slot;
    int unsigned                   pick;
    int unsigned                   resolves;

    clk_i                    = 1'b0;
    rst_ni                   = 1'b0;
    branch_in.valid          = 1'b0;
    branch_in.func           = bbp_pkg::FuncRegister;
    branch_in.address        = '0;
    branch_in.target_address = '0;
    result_out.ready         = 1'b0;
    cycle_count              = 0;
    event_count              = 0;
    register_count           = 0;
    resolve_count            = 0;
    result_count             = 0;
    mispredict_count         = 0;
    taken_pred_count         = 0;
    error_count              = 0;
    send_idle_pct            = 29;
    recv_idle_pct            = 74;
    for (int i = 0; i < bbp_pkg::TableEntriesDef; i++) begin
      bht_valid[i] = 1'b0;
      bht_ctr[i]   = bbp_pkg::CtrStrongNotTaken;
    end
    last_branch_addr = '0;
    last_target_addr = '0;
    last_prediction  = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    for (int r = 0; r < DirectedRows; r++) begin
      send_branch_event(directed_rows[r].func, directed_rows[r].addr,
                        directed_rows[r].target, directed_rows[r].typed,
                        directed_rows[r].outcome);
    end

    // A pool of recurring branches, each with its own habit; the upper half
    // shares table entries with the lower half through different high bits.
    for (int i = 0; i < PoolSize; i++) begin
      if (i < PoolSize / 2) begin
        branch_pool[i] = {$urandom, $urandom};
      end else begin
        branch_pool[i] = {~branch_pool[i - PoolSize / 2][bbp_pkg::AddrWidth-1:12],
                          branch_pool[i - PoolSize / 2][11:0]};
      end
      case (i % 4)
        0: begin
          pool_bias[i] = 95;
        end
        1: begin
          pool_bias[i] = 5;
        end
        default: begin
          pool_bias[i] = $urandom_range(100);
        end
      endcase
    end

    // Random part: mostly register-then-resolve pairs, some stray items.
    while (event_count < DirectedRows + RandomItems) begin
      if (event_count < DirectedRows + RandomItems / 3) begin
        send_idle_pct = 29;
        recv_idle_pct = 74;
      end else if (event_count < DirectedRows + 2 * RandomItems / 3) begin
        send_idle_pct = 74;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        slot        = $urandom_range(PoolSize - 1);
        branch_addr = ($urandom_range(4) == 0) ? {$urandom, $urandom} : branch_pool[slot];
        target      = {$urandom, $urandom};
        send_branch_event(bbp_pkg::FuncRegister, branch_addr, target, 1'b0, OutQuiet);
        resolves = ($urandom_range(9) == 0) ? $urandom_range(4, 2) : 1;
        repeat (resolves) begin
          if ($urandom_range(99) < pool_bias[slot]) begin
            next_addr = target;
          end else if ($urandom_range(1) == 0) begin
            next_addr = target + 64'd4;
          end else begin
            next_addr = {$urandom, $urandom};
          end
          send_branch_event(bbp_pkg::FuncResolve, next_addr, {$urandom, $urandom},
                            1'b0, OutQuiet);
        end
      end else if (pick < 90) begin
        send_branch_event(bbp_pkg::FuncRegister, {$urandom, $urandom},
                          {$urandom, $urandom}, 1'b0, OutQuiet);
      end else begin
        next_addr = ($urandom_range(1) == 0) ? last_target_addr : {$urandom, $urandom};
        send_branch_event(bbp_pkg::FuncResolve, next_addr, {$urandom, $urandom},
                          1'b0, OutQuiet);
      end
    end
    branch_in.valid <= 1'b0;

    // Drain the outstanding results, then allow for any late stray output.
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d branch registrations and %0d resolves under three idling phases.",
             register_count, resolve_count);
    $display("Checked %0d results: %0d taken predictions, %0d mispredicts.",
             result_count, taken_pred_count, mispredict_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
